@@ rtl/kmp_pkg.sv @@
// Package with shared types, codes and the macro sequence table of the keystroke macro player.
package kmp_pkg;

    localparam int SEQ_DEPTH_DEFAULT = 16;

    localparam logic [8:0]  DELAY_RESET   = 9'd50;
    localparam logic [9:0]  TRIGGER_RESET = 10'd8;
    localparam logic        ENABLE_RESET  = 1'b1;

    localparam logic [4:0]  EVENT_TYPE_KEY = 5'd1;

    typedef enum logic [1:0] {
        CFG_ENABLE  = 2'd0,
        CFG_DELAY   = 2'd1,
        CFG_TRIGGER = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_KEY  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KEY_RELEASE = 2'd0,
        KEY_PRESS   = 2'd1
    } key_value_t;

    typedef struct packed {
        logic       enable;
        logic [8:0] delay_ticks;
        logic [9:0] trigger_code;
    } cfg_t;

    typedef struct packed {
        logic       swallow;
        logic       emit_valid;
        logic [7:0] emit_code;
        logic       emit_pressed;
    } result_t;

    // Stored macro codes; entries past the initial list are zero.
    function automatic logic [7:0] seq_code(input logic [7:0] idx);
        logic [7:0] code;
        case (idx)
            8'd0:    code = 8'h23;
            8'd1:    code = 8'h12;
            8'd2:    code = 8'h26;
            8'd3:    code = 8'h26;
            8'd4:    code = 8'h18;
            8'd5:    code = 8'h39;
            8'd6:    code = 8'h11;
            8'd7:    code = 8'h18;
            8'd8:    code = 8'h13;
            8'd9:    code = 8'h26;
            8'd10:   code = 8'h20;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/kmp_cfg.sv @@
// Configuration register bank of the keystroke macro player.
module kmp_cfg
    import kmp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ENABLE:  cfg_next.enable       = cfg_data[0];
                CFG_DELAY:   cfg_next.delay_ticks  = cfg_data[8:0];
                CFG_TRIGGER: cfg_next.trigger_code = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable       <= ENABLE_RESET;
            cfg_reg.delay_ticks  <= DELAY_RESET;
            cfg_reg.trigger_code <= TRIGGER_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/kmp_ctrl.sv @@
// Playback state and per-beat result logic of the keystroke macro player.
module kmp_ctrl
    import kmp_pkg::*;
#(
    parameter int SEQ_DEPTH = SEQ_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       accept,
    input  logic       operation,
    input  logic [4:0] event_type,
    input  logic [9:0] key_code,
    input  logic [1:0] key_value,
    output result_t    res
);

    localparam int PosW = $clog2(SEQ_DEPTH + 1);
    localparam int IdxW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;

    logic            busy_reg;
    logic            busy_next;
    logic            release_next_reg;
    logic            release_next_next;
    logic [PosW-1:0] position_reg;
    logic [PosW-1:0] position_next;
    logic [8:0]      remaining_reg;
    logic [8:0]      remaining_next;

    logic            trigger_hit;
    logic            in_range;
    logic [IdxW-1:0] seq_idx;
    logic [7:0]      seq_key;

    assign trigger_hit = cfg.enable && (event_type == EVENT_TYPE_KEY) && !busy_reg
                         && (key_code == cfg.trigger_code);
    assign in_range    = position_reg < PosW'(SEQ_DEPTH);
    assign seq_idx     = position_reg[IdxW-1:0];
    assign seq_key     = in_range ? seq_code(8'(seq_idx)) : 8'h00;

    always_comb
    begin
        busy_next         = busy_reg;
        release_next_next = release_next_reg;
        position_next     = position_reg;
        remaining_next    = remaining_reg;
        res               = '0;
        if (operation == OP_KEY)
        begin
            if (trigger_hit)
            begin
                case (key_value)
                    KEY_RELEASE:
                    begin
                        busy_next         = 1'b1;
                        release_next_next = 1'b0;
                        position_next     = '0;
                        remaining_next    = '0;
                        res.swallow       = 1'b1;
                    end
                    KEY_PRESS:
                    begin
                        res.swallow = 1'b1;
                    end
                    default:
                    begin
                        res.swallow = 1'b0;
                    end
                endcase
            end
        end
        else if (busy_reg)
        begin
            if (remaining_reg > 9'd1)
            begin
                remaining_next = remaining_reg - 9'd1;
            end
            else if (seq_key == 8'h00)
            begin
                remaining_next    = '0;
                busy_next         = 1'b0;
                release_next_next = 1'b0;
            end
            else
            begin
                res.emit_valid   = 1'b1;
                res.emit_code    = seq_key;
                res.emit_pressed = !release_next_reg;
                remaining_next   = cfg.delay_ticks;
                if (!release_next_reg)
                begin
                    release_next_next = 1'b1;
                end
                else
                begin
                    release_next_next = 1'b0;
                    position_next     = position_reg + PosW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            release_next_reg <= 1'b0;
            position_reg     <= '0;
            remaining_reg    <= '0;
        end
        else if (accept)
        begin
            busy_reg         <= busy_next;
            release_next_reg <= release_next_next;
            position_reg     <= position_next;
            remaining_reg    <= remaining_next;
        end
    end

    // A tick never starts playback.
    a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (operation == OP_TICK) && !busy_reg |=> !busy_reg)
        else $error("tick started playback");

    // Playback begins only from an accepted key event beat.
    a_start_key: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(accept && (operation == OP_KEY)))
        else $error("playback started without a key event");

    // A pending release exists only during playback.
    a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
        release_next_reg |-> busy_reg)
        else $error("pending release while idle");

    // Synthetic events and swallowing never share a beat.
    a_emit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res.emit_valid |-> !res.swallow && busy_reg)
        else $error("emit on a key event or while idle");

endmodule

@@ rtl/kmp_obuf.sv @@
// Result register between the playback logic and the output channel.
module kmp_obuf
    import kmp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  result_t res,
    input  logic    out_stall,
    output logic    out_valid,
    output logic    in_stall,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign in_stall   = valid_reg && out_stall;
    assign valid_next = accept || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

@@ rtl/keystroke_macro_player.sv @@
// Top level of the keystroke macro player.
// Each accepted input beat's result is registered and shown on the output in the next cycle.
// One item per cycle if out_stall is low; the single result register refills as it drains.
// The macro sequence is a constant table, so no clearing pass follows reset.
// Reset: playback idle, output empty, enable 1, delay 50 ticks, trigger code 8.
// Configuration writes are taken in every cycle.
module keystroke_macro_player
    import kmp_pkg::*;
#(
    parameter int SEQ_DEPTH = SEQ_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       operation,
    input  logic [4:0] event_type,
    input  logic [9:0] key_code,
    input  logic [1:0] key_value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       swallow,
    output logic       emit_valid,
    output logic [7:0] emit_code,
    output logic       emit_pressed,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_data
);

    cfg_t    cfg;
    result_t res;
    result_t out_res;
    logic    accept;

    assign accept = in_valid && !in_stall;

    kmp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kmp_ctrl #(
        .SEQ_DEPTH (SEQ_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .accept     (accept),
        .operation  (operation),
        .event_type (event_type),
        .key_code   (key_code),
        .key_value  (key_value),
        .res        (res)
    );

    kmp_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .in_stall  (in_stall),
        .out_res   (out_res)
    );

    assign swallow      = out_res.swallow;
    assign emit_valid   = out_res.emit_valid;
    assign emit_code    = out_res.emit_code;
    assign emit_pressed = out_res.emit_pressed;

endmodule
